// ===== sv/sb64_pkg.sv =====
// Shared types, constants and alphabet decode for the base64url decoder.
`timescale 1ns / 1ps

package sb64_pkg;

   localparam int CHAR_W = 13;

   localparam logic [CHAR_W-1:0] CHAR_TOTAL = 13'd512;
   localparam logic [CHAR_W-1:0] BYTE_TOTAL = 13'd384;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   localparam logic [5:0] LOWER_BASE = 6'd26;
   localparam logic [5:0] DIGIT_BASE = 6'd52;
   localparam logic [5:0] DASH_VAL   = 6'd62;
   localparam logic [5:0] UNDER_VAL  = 6'd63;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_valid;
      logic       done_res;
      logic       accepted;
   } rsp_type;

   typedef struct packed {
      logic [5:0]        leftover_bits;
      logic [2:0]        leftover_count;
      logic [CHAR_W-1:0] chars_seen;
      logic [CHAR_W-1:0] bytes_given;
      logic              error_seen;
   } state_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] ch);
      sextet_type s;
      s.valid = 1'b1;
      s.value = 6'd0;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
         s.value = 6'(ch - CH_UPPER_A);
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
         s.value = 6'(ch - CH_LOWER_A) + LOWER_BASE;
      end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
         s.value = 6'(ch - CH_DIGIT_0) + DIGIT_BASE;
      end else if (ch == CH_DASH) begin
         s.value = DASH_VAL;
      end else if (ch == CH_UNDER) begin
         s.value = UNDER_VAL;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

// ===== sv/sb64_step.sv =====
// Next-state and result logic for one character of the base64url decoder.
`timescale 1ns / 1ps

module sb64_step import sb64_pkg::*; (
   input  state_type state,
   input  req_type   req,
   output state_type state_in,
   output rsp_type   rsp
);

   sextet_type       sx;
   logic [11:0]      acc;
   logic [3:0]       cnt;
   logic [2:0]       rem;
   logic [11:0]      mask;
   state_type        nxt;

   always_comb begin
      nxt  = state;
      rsp  = '0;
      sx   = sextet_of(req.symbol);
      acc  = {state.leftover_bits, sx.value};
      cnt  = {1'b0, state.leftover_count} + 4'd6;
      rem  = 3'(cnt - 4'd8);
      mask = (12'd1 << rem) - 12'd1;

      if (state.chars_seen >= CHAR_TOTAL) begin
         nxt.error_seen = 1'b1;
      end else begin
         nxt.chars_seen = state.chars_seen + 13'd1;
      end

      if (!sx.valid) begin
         nxt.error_seen = 1'b1;
      end

      if (!nxt.error_seen) begin
         if (cnt >= 4'd8) begin
            if (state.bytes_given >= BYTE_TOTAL) begin
               nxt.error_seen = 1'b1;
            end else begin
               rsp.byte_out       = 8'(acc >> rem);
               rsp.byte_valid     = 1'b1;
               nxt.bytes_given    = state.bytes_given + 13'd1;
               nxt.leftover_bits  = 6'(acc & mask);
               nxt.leftover_count = rem;
            end
         end else begin
            nxt.leftover_bits  = acc[5:0];
            nxt.leftover_count = cnt[2:0];
         end
      end

      rsp.done_res = req.last;
      rsp.accepted = req.last && !nxt.error_seen &&
                     nxt.chars_seen == CHAR_TOTAL &&
                     nxt.bytes_given == BYTE_TOTAL &&
                     nxt.leftover_count == 3'd0 &&
                     nxt.leftover_bits == 6'd0;

      state_in = req.last ? '0 : nxt;
   end

endmodule

// ===== sv/strict_base64url_decoder_unit.sv =====
// Top level: strict unpadded base64url decoder, one character per word.
// An accepted req word has its rsp word in the output register in the cycle after it is taken.
// Throughput: one word per cycle; req_ready stays high while the output register
// is empty or being drained the same cycle, so stalls come only from rsp_ready.
// Reset: synchronous, active high; clears the decode state and the output valid.
`timescale 1ns / 1ps

module strict_base64url_decoder_unit import sb64_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      req_take;

   sb64_step u_step (
      .state    (state_ff),
      .req      (req_data),
      .state_in (state_in),
      .rsp      (rsp_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
